// ----- hdl/mktd_pkg.sv -----
// shared types, constants and the morse tree table for the key timing decoder
// no dependencies
package mktd_pkg;

    localparam int DUR_W  = 24;
    localparam int UNIT_W = 16;
    localparam int POS_W  = 6;
    localparam int CHAR_W = 7;

    localparam logic [UNIT_W-1:0] UNIT_MS_RESET = 16'd100;
    localparam logic [CHAR_W-1:0] CHAR_NONE     = 7'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE    = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE  = 7'h0A;
    localparam logic [POS_W-1:0]  POS_ROOT      = 6'd0;

    typedef enum logic
    {
        KIND_PRESS = 1'b0,
        KIND_GAP   = 1'b1
    } kind_t;

    typedef struct packed
    {
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  dot;
        logic [POS_W-1:0]  dash;
    } tree_node_t;

    // child index 0 means no child
    function automatic tree_node_t tree_node(input logic [POS_W-1:0] pos);
        tree_node_t n;
        n = '{ch: CHAR_NONE, dot: 6'd0, dash: 6'd0};
        case (pos)
            6'd0:  n = '{ch: CHAR_NONE, dot: 6'd1,  dash: 6'd2};
            6'd1:  n = '{ch: 7'h45,     dot: 6'd3,  dash: 6'd4};
            6'd2:  n = '{ch: 7'h54,     dot: 6'd5,  dash: 6'd6};
            6'd3:  n = '{ch: 7'h49,     dot: 6'd7,  dash: 6'd8};
            6'd4:  n = '{ch: 7'h41,     dot: 6'd9,  dash: 6'd10};
            6'd5:  n = '{ch: 7'h4E,     dot: 6'd11, dash: 6'd12};
            6'd6:  n = '{ch: 7'h4D,     dot: 6'd13, dash: 6'd14};
            6'd7:  n = '{ch: 7'h53,     dot: 6'd15, dash: 6'd16};
            6'd8:  n = '{ch: 7'h55,     dot: 6'd17, dash: 6'd18};
            6'd9:  n = '{ch: 7'h52,     dot: 6'd19, dash: 6'd0};
            6'd10: n = '{ch: 7'h57,     dot: 6'd20, dash: 6'd21};
            6'd11: n = '{ch: 7'h44,     dot: 6'd22, dash: 6'd23};
            6'd12: n = '{ch: 7'h4B,     dot: 6'd24, dash: 6'd25};
            6'd13: n = '{ch: 7'h47,     dot: 6'd26, dash: 6'd27};
            6'd14: n = '{ch: 7'h4F,     dot: 6'd28, dash: 6'd29};
            6'd15: n = '{ch: 7'h48,     dot: 6'd30, dash: 6'd31};
            6'd16: n = '{ch: 7'h56,     dot: 6'd0,  dash: 6'd32};
            6'd17: n = '{ch: 7'h46,     dot: 6'd0,  dash: 6'd0};
            6'd18: n = '{ch: CHAR_NONE, dot: 6'd0,  dash: 6'd33};
            6'd19: n = '{ch: 7'h4C,     dot: 6'd0,  dash: 6'd0};
            6'd20: n = '{ch: 7'h50,     dot: 6'd0,  dash: 6'd0};
            6'd21: n = '{ch: 7'h4A,     dot: 6'd0,  dash: 6'd34};
            6'd22: n = '{ch: 7'h42,     dot: 6'd35, dash: 6'd0};
            6'd23: n = '{ch: 7'h58,     dot: 6'd0,  dash: 6'd0};
            6'd24: n = '{ch: 7'h43,     dot: 6'd0,  dash: 6'd0};
            6'd25: n = '{ch: 7'h59,     dot: 6'd0,  dash: 6'd0};
            6'd26: n = '{ch: 7'h5A,     dot: 6'd36, dash: 6'd0};
            6'd27: n = '{ch: 7'h51,     dot: 6'd0,  dash: 6'd0};
            6'd28: n = '{ch: CHAR_NONE, dot: 6'd37, dash: 6'd0};
            6'd29: n = '{ch: CHAR_NONE, dot: 6'd38, dash: 6'd39};
            6'd30: n = '{ch: 7'h35,     dot: 6'd0,  dash: 6'd0};
            6'd31: n = '{ch: 7'h34,     dot: 6'd0,  dash: 6'd0};
            6'd32: n = '{ch: 7'h33,     dot: 6'd0,  dash: 6'd0};
            6'd33: n = '{ch: 7'h32,     dot: 6'd0,  dash: 6'd0};
            6'd34: n = '{ch: 7'h31,     dot: 6'd0,  dash: 6'd0};
            6'd35: n = '{ch: 7'h36,     dot: 6'd0,  dash: 6'd0};
            6'd36: n = '{ch: 7'h37,     dot: 6'd0,  dash: 6'd0};
            6'd37: n = '{ch: 7'h38,     dot: 6'd0,  dash: 6'd0};
            6'd38: n = '{ch: 7'h39,     dot: 6'd0,  dash: 6'd0};
            6'd39: n = '{ch: 7'h30,     dot: 6'd0,  dash: 6'd0};
            default: n = '{ch: CHAR_NONE, dot: 6'd0, dash: 6'd0};
        endcase
        return n;
    endfunction

endpackage

// ----- hdl/morse_key_timing_decoder_top.sv -----
// morse key timing decoder: input register, threshold compare and tree step, result register
// depends on mktd_pkg
//
// Takes one key event per clock cycle while the output side keeps up, and turns press and
// gap durations into ASCII letters, digits, spaces and newlines. An item is held in the
// input register while it is decoded, and its results leave from the output register.
// Thresholds come from unit_ms by shift-and-add, followed by 24-bit compares against the
// registered duration. Most items give zero or one result and the block sustains one item
// per cycle when the downstream side is ready; a long gap that closes a letter gives two
// results, which leave one after the other and hold the input side until the second is
// taken. unit_ms may be written only while the block is idle.
module morse_key_timing_decoder_top
    import mktd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [UNIT_W-1:0]   cfg_data,       // unit_ms
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [DUR_W-1:0]    s_axis_tdata,   // duration_ms[23:0]
    input  logic [0:0]          s_axis_tuser,   // kind[0]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // char_code[6:0], zero[7]
    output logic [0:0]          m_axis_tuser,   // decode_error[0]
    output logic                m_axis_tlast
);

    logic [UNIT_W-1:0] unit_reg;
    logic              in_valid_reg;
    kind_t             in_kind_reg;
    logic [DUR_W-1:0]  in_dur_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic              off_reg;
    logic              off_next;
    logic              phase_reg;
    logic              phase_next;
    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic              out_err_reg;
    logic              out_last_reg;

    logic [DUR_W-1:0]  thr1, thr2, thr5, thr10, thr15;
    logic              is_gap, is_dot, is_dash, is_space, is_nl, letter_end, gap_space;
    logic              has_letter, emit_letter;
    logic [1:0]        n_res;
    tree_node_t        node;
    logic [POS_W-1:0]  child;
    logic [CHAR_W-1:0] letter_ch;
    logic [CHAR_W-1:0] res_char;
    logic              res_err;
    logic              res_last;
    logic              out_free;
    logic              emit;
    logic              done;
    logic              in_accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg <= UNIT_MS_RESET;
        end
        else if (cfg_valid)
        begin
            unit_reg <= cfg_data;
        end
    end

    // thresholds by shift and add
    always_comb
    begin
        thr1  = {8'd0, unit_reg};
        thr2  = {7'd0, unit_reg, 1'b0};
        thr5  = {6'd0, unit_reg, 2'b00} + {8'd0, unit_reg};
        thr10 = {thr5[DUR_W-2:0], 1'b0};
        thr15 = thr10 + thr5;
    end

    always_comb
    begin
        is_gap      = (in_kind_reg == KIND_GAP);
        is_dot      = !is_gap && (in_dur_reg <= thr1);
        is_dash     = !is_gap && !is_dot && (in_dur_reg <= thr5);
        is_space    = !is_gap && (in_dur_reg > thr5) && (in_dur_reg <= thr10);
        is_nl       = !is_gap && (in_dur_reg > thr10) && (in_dur_reg <= thr15);
        letter_end  = is_gap && (in_dur_reg > thr2);
        gap_space   = is_gap && (in_dur_reg > thr5);
        has_letter  = letter_end && (off_reg || (pos_reg != POS_ROOT));
        node        = tree_node(pos_reg);
        letter_ch   = off_reg ? CHAR_NONE : node.ch;
        child       = is_dash ? node.dash : node.dot;
        n_res       = 2'(is_space) + 2'(is_nl) + 2'(has_letter) + 2'(gap_space);
        emit_letter = has_letter && !phase_reg;
        res_char    = emit_letter ? letter_ch : (is_nl ? CHAR_NEWLINE : CHAR_SPACE);
        res_err     = emit_letter && (letter_ch == CHAR_NONE);
        res_last    = !(emit_letter && gap_space);
    end

    always_comb
    begin
        out_free      = !out_valid_reg || m_axis_tready;
        emit          = in_valid_reg && (n_res != 2'd0) && out_free;
        done          = in_valid_reg && ((n_res == 2'd0) || (emit && res_last));
        s_axis_tready = !in_valid_reg || done;
        in_accept     = s_axis_tvalid && s_axis_tready;
    end

    // tree state and result phase
    always_comb
    begin
        pos_next   = pos_reg;
        off_next   = off_reg;
        phase_next = phase_reg;
        if (emit && !res_last)
        begin
            phase_next = 1'b1;
        end
        if (done)
        begin
            phase_next = 1'b0;
            if (letter_end)
            begin
                pos_next = POS_ROOT;
                off_next = 1'b0;
            end
            else if ((is_dot || is_dash) && !off_reg)
            begin
                if (child == POS_ROOT)
                begin
                    off_next = 1'b1;
                end
                else
                begin
                    pos_next = child;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            pos_reg       <= POS_ROOT;
            off_reg       <= 1'b0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            off_reg   <= off_next;
            phase_reg <= phase_next;
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (done)
            begin
                in_valid_reg <= 1'b0;
            end
            if (out_free)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_kind_reg <= kind_t'(s_axis_tuser[0]);
            in_dur_reg  <= s_axis_tdata;
        end
        if (emit)
        begin
            out_char_reg <= res_char;
            out_err_reg  <= res_err;
            out_last_reg <= res_last;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {1'b0, out_char_reg};
    assign m_axis_tuser[0] = out_err_reg;
    assign m_axis_tlast    = out_last_reg;

endmodule

// ----- hdl/mktd_checker.sv -----
// port-level checks for the morse key timing decoder, bound to the top level
// depends on mktd_pkg and morse_key_timing_decoder_top
module mktd_port_props
    import mktd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic [UNIT_W-1:0]   cfg_data,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic [DUR_W-1:0]    s_axis_tdata,
    input logic [0:0]          s_axis_tuser,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [7:0]          m_axis_tdata,
    input logic [0:0]          m_axis_tuser,
    input logic                m_axis_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // error item carries no character
    a_err_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[6:0] == CHAR_NONE)
        else $error("error item with a character");

    // only a letter can be followed by another item of the same event
    a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[6:0] != CHAR_SPACE
            && m_axis_tdata[6:0] != CHAR_NEWLINE)
        else $error("space or newline not last");

    // pad bit stays zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[7])
        else $error("pad bit set");

endmodule

bind morse_key_timing_decoder_top mktd_port_props u_mktd_checker (.*);

// ----- verif/mktd_checker.sv -----
// checker for the morse key timing decoder: watches the config, key and char channels,
// predicts the decoded chars and compares every char item field by field
// depends on mktd_pkg
module mktd_checker
    import mktd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [UNIT_W-1:0]   cfg_data,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [DUR_W-1:0]    s_axis_tdata,
    input  logic [0:0]          s_axis_tuser,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [7:0]          m_axis_tdata,
    input  logic [0:0]          m_axis_tuser,
    input  logic                m_axis_tlast,
    output int                  mismatches,
    output int                  chars_pending,
    output int                  chars_checked
);

    typedef struct packed
    {
        logic [CHAR_W-1:0] ch;
        logic              err;
        logic              last;
    } char_item_t;

    char_item_t         char_queue[$];

    // tree held as a heap: 1 is the root, dot goes to 2n, dash to 2n+1
    logic [CHAR_W-1:0]  glyph_at[128];
    bit                 node_exists[128];

    logic [UNIT_W-1:0]  unit_copy;
    int                 node;
    bit                 lost;

    task automatic add_code(input string code, input byte ch);
        int idx;
        idx = 1;
        for (int i = 0; i < code.len(); i++)
        begin
            idx = 2 * idx + ((code[i] == "-") ? 1 : 0);
            node_exists[idx] = 1'b1;
        end
        glyph_at[idx] = ch[CHAR_W-1:0];
    endtask

    initial
    begin
        for (int i = 0; i < 128; i++)
        begin
            glyph_at[i]    = CHAR_NONE;
            node_exists[i] = 1'b0;
        end
        node_exists[1] = 1'b1;
        add_code(".", "E");      add_code("-", "T");      add_code("..", "I");
        add_code(".-", "A");     add_code("-.", "N");     add_code("--", "M");
        add_code("...", "S");    add_code("..-", "U");    add_code(".-.", "R");
        add_code(".--", "W");    add_code("-..", "D");    add_code("-.-", "K");
        add_code("--.", "G");    add_code("---", "O");    add_code("....", "H");
        add_code("...-", "V");   add_code("..-.", "F");   add_code(".-..", "L");
        add_code(".--.", "P");   add_code(".---", "J");   add_code("-...", "B");
        add_code("-..-", "X");   add_code("-.-.", "C");   add_code("-.--", "Y");
        add_code("--..", "Z");   add_code("--.-", "Q");   add_code(".....", "5");
        add_code("....-", "4");  add_code("...--", "3");  add_code("..---", "2");
        add_code(".----", "1");  add_code("-....", "6");  add_code("--...", "7");
        add_code("---..", "8");  add_code("----.", "9");  add_code("-----", "0");
    end

    task automatic step_tree(input bit dash);
        int nxt;
        if (!lost)
        begin
            nxt = 2 * node + (dash ? 1 : 0);
            if (nxt > 127 || !node_exists[nxt])
                lost = 1'b1;
            else
                node = nxt;
        end
    endtask

    task automatic decode_key_event(input kind_t kind, input logic [DUR_W-1:0] dur);
        int unsigned       u;
        int unsigned       d;
        char_item_t        found[2];
        int                n;
        logic [CHAR_W-1:0] ch;
        u = unit_copy;
        d = dur;
        n = 0;
        if (kind == KIND_PRESS)
        begin
            if (d <= u)
                step_tree(1'b0);
            else if (d <= 5 * u)
                step_tree(1'b1);
            else if (d <= 10 * u)
            begin
                found[n] = '{ch: CHAR_SPACE, err: 1'b0, last: 1'b0};
                n++;
            end
            else if (d <= 15 * u)
            begin
                found[n] = '{ch: CHAR_NEWLINE, err: 1'b0, last: 1'b0};
                n++;
            end
        end
        else if (d > 2 * u)
        begin
            if (lost || node != 1)
            begin
                ch = lost ? CHAR_NONE : glyph_at[node];
                found[n] = '{ch: ch, err: (ch == CHAR_NONE), last: 1'b0};
                n++;
            end
            node = 1;
            lost = 1'b0;
            if (d > 5 * u)
            begin
                found[n] = '{ch: CHAR_SPACE, err: 1'b0, last: 1'b0};
                n++;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
                found[i].last = 1'b1;
            char_queue.push_back(found[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        char_item_t want;
        if (!rst_n)
        begin
            unit_copy = UNIT_MS_RESET;
            node      = 1;
            lost      = 1'b0;
            char_queue.delete();
            mismatches    <= 0;
            chars_pending <= 0;
            chars_checked <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                unit_copy = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                decode_key_event(kind_t'(s_axis_tuser[0]), s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (char_queue.size() == 0)
                begin
                    $error("char_code: expected no item, got %02h", m_axis_tdata[6:0]);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = char_queue.pop_front();
                    chars_checked <= chars_checked + 1;
                    if (m_axis_tdata[6:0] !== want.ch ||
                        m_axis_tdata[7] !== 1'b0 ||
                        m_axis_tuser[0] !== want.err ||
                        m_axis_tlast !== want.last)
                        mismatches <= mismatches + 1;
                    if (m_axis_tdata[6:0] !== want.ch)
                        $error("char_code: expected %02h, got %02h", want.ch, m_axis_tdata[6:0]);
                    if (m_axis_tdata[7] !== 1'b0)
                        $error("tdata pad: expected 0, got %b", m_axis_tdata[7]);
                    if (m_axis_tuser[0] !== want.err)
                        $error("decode_error: expected %b, got %b", want.err, m_axis_tuser[0]);
                    if (m_axis_tlast !== want.last)
                        $error("last: expected %b, got %b", want.last, m_axis_tlast);
                end
            end
            chars_pending <= char_queue.size();
        end
    end

endmodule

// ----- verif/tb.sv -----
// testbench top for the morse key timing decoder: clock, reset, key and config stimulus
// depends on mktd_pkg, mktd_checker and morse_key_timing_decoder_top
module tb;
    import mktd_pkg::*;

    localparam int unsigned DUR_MAX     = 24'hFFFFFF;
    localparam int          CYCLE_LIMIT = 600000;
    localparam int          LONG_HOLD   = 300;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic [UNIT_W-1:0]  cfg_data      = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [DUR_W-1:0]   s_axis_tdata  = '0;   // duration_ms[23:0]
    logic [0:0]         s_axis_tuser  = '0;   // kind[0]
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [7:0]         m_axis_tdata;         // char_code[6:0], zero[7]
    logic [0:0]         m_axis_tuser;         // decode_error[0]
    logic               m_axis_tlast;

    int                 mismatches;
    int                 chars_pending;
    int                 chars_checked;

    int                 cycle_count = 0;
    int                 keys_sent   = 0;
    int                 unit_writes = 0;
    int unsigned        unit_now    = UNIT_MS_RESET;
    bit                 src_idle    = 1'b1;
    bit                 sink_idle   = 1'b1;
    int                 hold_asks   = 0;
    int                 holds_done  = 0;

    morse_key_timing_decoder_top DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast)
    );

    mktd_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .mismatches     (mismatches),
        .chars_pending  (chars_pending),
        .chars_checked  (chars_checked)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin : sink
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_asks)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
                m_axis_tready <= 1'b1;
            end
            else if (sink_idle && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 19);
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    function automatic int unsigned dur_between(input int unsigned lo, input int unsigned hi);
        if (lo > DUR_MAX)
            lo = DUR_MAX;
        if (hi > DUR_MAX)
            hi = DUR_MAX;
        if (hi <= lo)
            return lo;
        return $urandom_range(hi, lo);
    endfunction

    task automatic offer_key(input kind_t kind, input int unsigned dur);
        int gap;
        if (src_idle && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 19);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= DUR_W'((dur > DUR_MAX) ? DUR_MAX : dur);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // presses past the newline range are dropped by the block
        if (!(kind == KIND_PRESS && dur > 15 * unit_now))
            keys_sent++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (chars_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_unit(input int unsigned value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= UNIT_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        unit_now = value;
        unit_writes++;
    endtask

    task automatic key_letter();
        int          len;
        bit          dash;
        int unsigned u;
        u   = unit_now;
        len = ($urandom_range(0, 9) == 0) ? 6 : $urandom_range(1, 5);
        for (int i = 0; i < len; i++)
        begin
            dash = $urandom_range(0, 1);
            if (dash)
                offer_key(KIND_PRESS, dur_between(u + 1, 5 * u));
            else
                offer_key(KIND_PRESS, dur_between(0, u));
            if ($urandom_range(0, 15) == 0)
                offer_key(KIND_PRESS, $urandom_range(0, 1) ? dur_between(5 * u + 1, 10 * u)
                                                           : dur_between(10 * u + 1, 15 * u));
            if (i < len - 1 && $urandom_range(0, 3) != 0)
                offer_key(KIND_GAP, dur_between(0, 2 * u));
        end
        case ($urandom_range(0, 7))
            0, 1, 2, 3: offer_key(KIND_GAP, dur_between(2 * u + 1, 5 * u));
            4, 5, 6:    offer_key(KIND_GAP, dur_between(5 * u + 1, 20 * u));
            default:    offer_key(KIND_GAP, DUR_MAX);
        endcase
    endtask

    task automatic key_noise();
        kind_t       kind;
        int unsigned mark;
        kind = kind_t'($urandom_range(0, 1));
        if ($urandom_range(0, 2) == 0)
            offer_key(kind, $urandom() & DUR_MAX);
        else
        begin
            case ($urandom_range(0, 4))
                0:       mark = unit_now;
                1:       mark = 2 * unit_now;
                2:       mark = 5 * unit_now;
                3:       mark = 10 * unit_now;
                default: mark = 15 * unit_now;
            endcase
            offer_key(kind, dur_between((mark == 0) ? 0 : mark - 1, mark + 1));
        end
    endtask

    task automatic random_keys(input int count);
        int target;
        target = keys_sent + count;
        while (keys_sent < target)
        begin
            if ($urandom_range(0, 3) != 0)
                key_letter();
            else
                key_noise();
        end
    endtask

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // thresholds at the reset unit of 100 ms
        offer_key(KIND_PRESS, 0);
        offer_key(KIND_GAP, 200);
        offer_key(KIND_PRESS, 100);
        offer_key(KIND_PRESS, 1501);
        offer_key(KIND_GAP, 201);
        offer_key(KIND_PRESS, 101);
        offer_key(KIND_PRESS, 500);
        offer_key(KIND_PRESS, 501);
        offer_key(KIND_PRESS, 1000);
        offer_key(KIND_PRESS, 1001);
        offer_key(KIND_PRESS, 1500);
        offer_key(KIND_GAP, 500);
        offer_key(KIND_PRESS, DUR_MAX);
        // gaps at the root give only the space
        offer_key(KIND_GAP, DUR_MAX);
        offer_key(KIND_GAP, 300);
        // missing child past R, further keys stay off the tree
        offer_key(KIND_PRESS, 50);
        offer_key(KIND_PRESS, 300);
        offer_key(KIND_PRESS, 50);
        offer_key(KIND_PRESS, 300);
        offer_key(KIND_PRESS, 400);
        offer_key(KIND_GAP, 501);
        // node with no char
        offer_key(KIND_PRESS, 1);
        offer_key(KIND_PRESS, 99);
        offer_key(KIND_PRESS, 102);
        offer_key(KIND_PRESS, 499);
        offer_key(KIND_GAP, 201);

        random_keys(180);

        set_unit(1);
        random_keys(90);
        src_idle = 1'b0;
        hold_asks++;
        for (int i = 0; i < 60; i++)
            offer_key(KIND_PRESS, dur_between(6, 15));
        src_idle = 1'b1;
        random_keys(90);

        set_unit(16'hFFFF);
        random_keys(180);

        set_unit(0);
        random_keys(120);

        src_idle  = 1'b0;
        sink_idle = 1'b0;
        set_unit(3);
        random_keys(180);

        src_idle  = 1'b1;
        sink_idle = 1'b1;
        set_unit($urandom_range(6, 900));
        random_keys(180);

        set_unit($urandom_range(1000, 65534));
        random_keys(180);

        src_idle  = 1'b0;
        sink_idle = 1'b0;
        set_unit(UNIT_MS_RESET);
        random_keys(180);

        settle();
        repeat (8) @(posedge clk);

        $display("sent %0d key items over %0d unit writes, %0d char items checked",
                 keys_sent, unit_writes, chars_checked);
        if (mismatches == 0 && chars_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/mktd_pkg.sv
hdl/morse_key_timing_decoder_top.sv
hdl/mktd_checker.sv
verif/mktd_checker.sv
verif/tb.sv
